// ===== hw/rtl/mixed_script_query_tokenizer_assert.svh =====
// Assertion macros for the query tokenizer. Both sample on the rising edge of
// aclk and are switched off while aresetn is low.
`ifndef MIXED_SCRIPT_QUERY_TOKENIZER_ASSERT_SVH
`define MIXED_SCRIPT_QUERY_TOKENIZER_ASSERT_SVH

// A condition that must hold at every clock edge.
`define MSQT_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define MSQT_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/msqt_pkg.sv =====
`default_nettype none

package msqt_pkg;

    localparam int MAX_QUERY_BYTES = 1024;
    localparam int POS_W           = $clog2(MAX_QUERY_BYTES);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;

    localparam logic [7:0] WORD_MAX_RESET    = 8'd32;
    localparam logic [7:0] NUMBER_MAX_RESET  = 8'd16;
    localparam logic [7:0] CHINESE_MAX_RESET = 8'd100;
    localparam logic [7:0] CHINESE_HARD_CAP  = 8'd252;

    localparam logic [7:0] LEAD_LO   = 8'hb0;
    localparam logic [7:0] LEAD_HI   = 8'hf7;
    localparam logic [7:0] TRAIL_LO  = 8'ha1;
    localparam logic [7:0] TRAIL_HI  = 8'hfe;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;

    // Configuration register indexes.
    localparam logic [1:0] REG_WORD_MAX    = 2'd0;
    localparam logic [1:0] REG_NUMBER_MAX  = 2'd1;
    localparam logic [1:0] REG_CHINESE_MAX = 2'd2;

    // Token kinds.
    localparam logic [1:0] KIND_WORD    = 2'd0;
    localparam logic [1:0] KIND_NUMBER  = 2'd1;
    localparam logic [1:0] KIND_CHINESE = 2'd2;

    typedef enum logic [4:0] {
        MODE_IDLE     = 5'b00001,
        MODE_WORD     = 5'b00010,
        MODE_NUMBER   = 5'b00100,
        MODE_CH_TRAIL = 5'b01000,
        MODE_CH_LEAD  = 5'b10000
    } mode_t;

    typedef struct packed {
        logic       last;
        logic       negated;
        logic [7:0] length;
        logic [9:0] start;
        logic [1:0] kind;
    } desc_t;

    typedef struct packed {
        logic  emit;
        desc_t desc;
    } close_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_lead(input logic [7:0] c);
        return c >= LEAD_LO && c <= LEAD_HI;
    endfunction

    function automatic logic is_trail(input logic [7:0] c);
        return c >= TRAIL_LO && c <= TRAIL_HI;
    endfunction

    // Descriptor for closing the open token; a Chinese run is cut to even
    // length and gives nothing when that leaves it empty.
    function automatic close_t close_token(input mode_t mode, input logic [7:0] len,
                                           input logic [POS_W-1:0] start,
                                           input logic minus);
        close_t     r;
        logic [7:0] even;
        even           = {len[7:1], 1'b0};
        r.emit         = 1'b0;
        r.desc.last    = 1'b0;
        r.desc.negated = minus;
        r.desc.length  = len;
        r.desc.start   = start[9:0];
        r.desc.kind    = KIND_WORD;
        case (mode)
            MODE_WORD: begin
                r.emit = 1'b1;
            end
            MODE_NUMBER: begin
                r.emit      = 1'b1;
                r.desc.kind = KIND_NUMBER;
            end
            MODE_CH_TRAIL, MODE_CH_LEAD: begin
                r.emit        = (even != 8'd0);
                r.desc.kind   = KIND_CHINESE;
                r.desc.length = even;
            end
            default: begin
                r.emit = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mixed_script_query_tokenizer.sv =====
`default_nettype none
// Query tokenizer. Bytes of a query arrive on the s_ channel, one byte per
// item, with s_tlast set on the final byte of the query. For every token the
// block sends one descriptor item on the m_ channel: start position, length
// and negate flag on m_tdata and the token kind on m_tuser, with m_tlast set
// on the last descriptor caused by a given input byte. A byte causes zero,
// one or two descriptors.
// Registers are written on the cfg_ channel (index 0 word cap, 1 number cap,
// 2 Chinese byte cap); cfg_ready is always high. Write only while idle.
// The descriptors of a byte are computed in the cycle it is accepted and are
// offered on m_ from the next cycle on, behind any older ones still queued.
// Throughput: one byte per cycle while m_tready stays high and each byte
// causes at most one descriptor; two descriptors need two m_ transfers.
// The figure is set by the four-entry descriptor queue, which accepts a byte
// only while it has room for two descriptors.
// Reset (aresetn low, synchronous) empties the queue, drops any open token,
// clears the position and returns the caps to 32, 16 and 100.
// When the receiver stalls the queue fills and s_tready falls as soon as
// three descriptors are waiting; no descriptor is lost or repeated.
module mixed_script_query_tokenizer
    import msqt_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Query byte channel.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] query_byte
    input  wire logic                   s_tlast,   // end_of_query
    // Descriptor channel.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [9:0] token_start, [17:10] token_length, [18] negated, [23:19] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    output logic [1:0]                  m_tuser,   // [1:0] token_kind
    output logic                        m_tlast,   // last_of_run
    // Configuration write channel.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [7:0]             cfg_wdata
);

    logic [7:0] word_max_reg;
    logic [7:0] number_max_reg;
    logic [7:0] chinese_max_reg;

    mode_t            mode_reg,  mode_next,  mode_mid;
    logic [POS_W-1:0] start_reg, start_next, start_mid;
    logic [7:0]       len_reg,   len_next,   len_mid;
    logic             skip_reg,  skip_next,  skip_mid;
    logic             minus_reg, minus_next, minus_mid;
    logic             seen_reg,  seen_next,  seen_mid;
    logic [POS_W-1:0] pos_reg,   pos_next;

    desc_t              fifo_mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg,  count_next;

    logic       in_accept;
    logic       out_pop;
    logic       taken;
    logic       eoq;
    logic [7:0] c;
    close_t     close1;
    close_t     close2;
    desc_t      desc1;
    desc_t      desc2;
    desc_t      head;

    assign c         = s_tdata;
    assign eoq       = s_tlast;
    assign cfg_ready = 1'b1;
    assign s_tready  = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = (count_reg != '0);
    assign out_pop   = m_tvalid && m_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_max_reg    <= WORD_MAX_RESET;
            number_max_reg  <= NUMBER_MAX_RESET;
            chinese_max_reg <= CHINESE_MAX_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_WORD_MAX:    word_max_reg    <= cfg_wdata;
                REG_NUMBER_MAX:  number_max_reg  <= cfg_wdata;
                REG_CHINESE_MAX: chinese_max_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Scanner: the byte either extends the open token or closes it and is
    // then handled as a fresh byte. The end of the query closes whatever is
    // left open after that, which gives the possible second descriptor.
    always_comb begin
        mode_mid  = mode_reg;
        start_mid = start_reg;
        len_mid   = len_reg;
        minus_mid = minus_reg;
        seen_mid  = seen_reg;
        skip_mid  = 1'b0;
        close1    = '0;
        taken     = 1'b0;

        if (!skip_reg) begin
            case (mode_reg)
                MODE_WORD: begin
                    taken = (is_letter(c) || is_digit(c)) && (len_reg < word_max_reg);
                end
                MODE_NUMBER: begin
                    taken = is_digit(c) && (len_reg < number_max_reg);
                end
                MODE_CH_TRAIL: begin
                    taken = is_trail(c);
                end
                MODE_CH_LEAD: begin
                    taken = is_lead(c) && (len_reg < chinese_max_reg)
                            && (len_reg <= CHINESE_HARD_CAP);
                end
                default: begin
                    taken = 1'b0;
                end
            endcase

            if (taken) begin
                len_mid = len_reg + 8'd1;
                if (mode_reg == MODE_CH_TRAIL) begin
                    mode_mid = MODE_CH_LEAD;
                end else if (mode_reg == MODE_CH_LEAD) begin
                    mode_mid = MODE_CH_TRAIL;
                end
            end else begin
                close1 = close_token(mode_reg, len_reg, start_reg, minus_reg);
                if (mode_reg != MODE_IDLE) begin
                    mode_mid  = MODE_IDLE;
                    len_mid   = 8'd0;
                    minus_mid = 1'b0;
                end
                if (close1.emit) begin
                    seen_mid = 1'b1;
                end
                if (is_letter(c) || is_digit(c) || is_lead(c)) begin
                    mode_mid  = is_letter(c) ? MODE_WORD :
                                is_digit(c)  ? MODE_NUMBER : MODE_CH_TRAIL;
                    start_mid = pos_reg;
                    len_mid   = 8'd1;
                end else begin
                    if (c[7] && !eoq) begin
                        skip_mid = 1'b1;
                    end
                    if (c == CHAR_MINUS && seen_mid) begin
                        minus_mid = 1'b1;
                    end
                end
            end
        end

        close2 = '0;
        if (eoq) begin
            close2 = close_token(mode_mid, len_mid, start_mid, minus_mid);
        end

        desc1      = close1.desc;
        desc1.last = !close2.emit;
        desc2      = close2.desc;
        desc2.last = 1'b1;

        if (eoq) begin
            mode_next  = MODE_IDLE;
            start_next = '0;
            len_next   = 8'd0;
            skip_next  = 1'b0;
            minus_next = 1'b0;
            seen_next  = 1'b0;
            pos_next   = '0;
        end else begin
            mode_next  = mode_mid;
            start_next = start_mid;
            len_next   = len_mid;
            skip_next  = skip_mid;
            minus_next = minus_mid;
            seen_next  = seen_mid;
            pos_next   = (pos_reg == POS_W'(MAX_QUERY_BYTES - 1)) ? '0 : pos_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= 8'd0;
            skip_reg  <= 1'b0;
            minus_reg <= 1'b0;
            seen_reg  <= 1'b0;
            pos_reg   <= '0;
        end else if (in_accept) begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            skip_reg  <= skip_next;
            minus_reg <= minus_next;
            seen_reg  <= seen_next;
            pos_reg   <= pos_next;
        end
    end

    // Descriptor queue: up to two writes and one read per cycle.
    logic               push1;
    logic               push2;
    logic [FIFO_AW-1:0] wr_addr2;

    assign push1    = in_accept && close1.emit;
    assign push2    = in_accept && close2.emit;
    assign wr_addr2 = push1 ? wr_ptr_reg + 1'b1 : wr_ptr_reg;

    always_comb begin
        count_next = count_reg + FIFO_CW'(push1) + FIFO_CW'(push2) - FIFO_CW'(out_pop);
    end

    always_ff @(posedge aclk) begin
        if (push1) begin
            fifo_mem_reg[wr_ptr_reg] <= desc1;
        end
        if (push2) begin
            fifo_mem_reg[wr_addr2] <= desc2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push1) + FIFO_AW'(push2);
            if (out_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head    = fifo_mem_reg[rd_ptr_reg];
    assign m_tdata = {5'b00000, head.negated, head.length, head.start};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

    `include "mixed_script_query_tokenizer_assert.svh"

    // The queue never holds more descriptors than it has entries.
    `MSQT_ASSERT_ALWAYS(a_count_bound, count_reg <= FIFO_CW'(FIFO_DEPTH), "queue overflow")
    // With no token open, no length is carried over.
    `MSQT_ASSERT_ALWAYS(a_idle_len, (mode_reg != MODE_IDLE) || (len_reg == 8'd0), "idle len")
    // The end of a query returns the scanner to its start.
    `MSQT_ASSERT_NEXT(a_eoq_reset, in_accept && eoq,
                      (mode_reg == MODE_IDLE) && (pos_reg == '0) && !seen_reg,
                      "query end not cleared")

endmodule

`default_nettype wire

// ===== test/tb_mixed_script_query_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_mixed_script_query_tokenizer;
    import msqt_pkg::*;

    localparam int CLK_HALF_NS  = 10;
    localparam int RESET_CYCLES = 10;
    // Random bytes to send once the directed and corner tests are done.
    localparam int RANDOM_ITEMS = 250;
    // Cycles allowed after the last descriptor before the block counts as idle.
    // A descriptor is registered in the queue when its byte is accepted, so
    // this margin covers a byte that produced nothing.
    localparam int DRAIN_SETTLE = 8;
    // Length of the deliberate receiver hold-off, long enough to fill the queue.
    localparam int LONG_HOLD    = 80;
    localparam int CYCLE_LIMIT  = 500000;

    localparam logic [7:0] DEFAULT_WORD_CAP    = 8'd32;
    localparam logic [7:0] DEFAULT_NUMBER_CAP  = 8'd16;
    localparam logic [7:0] DEFAULT_CHINESE_CAP = 8'd100;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] start;
        logic [7:0] length;
        logic       negated;
        logic       last;
    } token_desc_t;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_MOSTLY,
        RX_PERIODIC
    } rx_pattern_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = '0;
    logic [7:0]             cfg_wdata = '0;

    mixed_script_query_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #(CLK_HALF_NS) aclk = ~aclk;

    // ------------------------------------------------------------------
    // Tokenizer predictor. This is a private copy of the scanner state that
    // advances once per accepted byte and queues the descriptors that byte
    // must produce.
    // ------------------------------------------------------------------
    mode_t       scan_mode;
    logic [9:0]  open_start;
    logic [7:0]  open_len;
    logic [9:0]  byte_pos;
    logic        skip_next;
    logic        minus_pending;
    logic        seen_token;
    logic [7:0]  word_cap;
    logic [7:0]  number_cap;
    logic [7:0]  chinese_cap;

    token_desc_t byte_tokens [2];
    int          byte_token_count;
    token_desc_t expected_tokens [$];

    int          error_count = 0;
    int          items_sent = 0;

    function automatic bit letter_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit digit_byte(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit lead_byte(input logic [7:0] c);
        return c >= LEAD_LO && c <= LEAD_HI;
    endfunction

    function automatic bit trail_byte(input logic [7:0] c);
        return c >= TRAIL_LO && c <= TRAIL_HI;
    endfunction

    function void clear_query_state();
        scan_mode     = MODE_IDLE;
        open_start    = '0;
        open_len      = '0;
        byte_pos      = '0;
        skip_next     = 1'b0;
        minus_pending = 1'b0;
        seen_token    = 1'b0;
    endfunction

    function void emit_token(input logic [1:0] kind, input logic [7:0] len);
        token_desc_t d;
        d.kind    = kind;
        d.start   = open_start;
        d.length  = len;
        d.negated = minus_pending;
        d.last    = 1'b0;
        byte_tokens[byte_token_count] = d;
        byte_token_count++;
        seen_token = 1'b1;
    endfunction

    // Closing a Chinese run drops its odd trailing lead byte, and a run left
    // empty by that produces nothing. The pending minus is consumed either way.
    function void close_open_token();
        case (scan_mode)
            MODE_WORD: begin
                emit_token(KIND_WORD, open_len);
            end
            MODE_NUMBER: begin
                emit_token(KIND_NUMBER, open_len);
            end
            MODE_CH_TRAIL, MODE_CH_LEAD: begin
                if (open_len[7:1] != 7'd0) emit_token(KIND_CHINESE, {open_len[7:1], 1'b0});
            end
            default: begin
                return;
            end
        endcase
        minus_pending = 1'b0;
        scan_mode     = MODE_IDLE;
        open_len      = '0;
    endfunction

    // A byte that no token takes either opens a new token or is a separator.
    // Separators of 0x80 and above hide the following byte, unless they end
    // the query.
    function void open_token_at(input logic [7:0] c, input bit eoq);
        if (letter_byte(c) || digit_byte(c) || lead_byte(c)) begin
            if (letter_byte(c)) scan_mode = MODE_WORD;
            else if (digit_byte(c)) scan_mode = MODE_NUMBER;
            else scan_mode = MODE_CH_TRAIL;
            open_start = byte_pos;
            open_len   = 8'd1;
        end else begin
            if (c >= 8'h80 && !eoq) skip_next = 1'b1;
            if (c == CHAR_MINUS && seen_token) minus_pending = 1'b1;
        end
    endfunction

    function void predict_query_byte(input logic [7:0] c, input bit eoq);
        bit taken;
        byte_token_count = 0;
        taken = 1'b0;
        if (skip_next) begin
            skip_next = 1'b0;
        end else begin
            case (scan_mode)
                MODE_WORD: begin
                    taken = (letter_byte(c) || digit_byte(c)) && open_len < word_cap;
                end
                MODE_NUMBER: begin
                    taken = digit_byte(c) && open_len < number_cap;
                end
                MODE_CH_TRAIL: begin
                    taken = trail_byte(c);
                    if (taken) scan_mode = MODE_CH_LEAD;
                end
                MODE_CH_LEAD: begin
                    // An odd cap lets one more pair in, but never past 254 bytes.
                    taken = lead_byte(c) && open_len < chinese_cap
                            && open_len <= CHINESE_HARD_CAP;
                    if (taken) scan_mode = MODE_CH_TRAIL;
                end
                default: begin
                    taken = 1'b0;
                end
            endcase
            if (taken) begin
                open_len++;
            end else begin
                // The byte that ends a token is looked at again as a fresh byte.
                close_open_token();
                open_token_at(c, eoq);
            end
        end
        if (eoq) begin
            close_open_token();
            clear_query_state();
        end else begin
            byte_pos++;
        end
        if (byte_token_count > 0) byte_tokens[byte_token_count - 1].last = 1'b1;
        for (int i = 0; i < byte_token_count; i++) expected_tokens.push_back(byte_tokens[i]);
    endfunction

    // ------------------------------------------------------------------
    // Query byte sender. Bytes are staged in a stream with their end-of-query
    // flags and then offered in bursts of random length separated by random
    // gaps. Valid stays high across a burst and only drops when a gap or the
    // end of the stream comes.
    // ------------------------------------------------------------------
    logic [7:0] stream_bytes [$];
    bit         stream_last [$];
    int         burst_left = 0;
    bit         steady_sender = 1'b0;

    function void push_byte(input logic [7:0] c);
        stream_bytes.push_back(c);
        stream_last.push_back(1'b0);
    endfunction

    function void mark_query_end();
        stream_last[stream_last.size() - 1] = 1'b1;
    endfunction

    task automatic send_query_byte(input logic [7:0] c, input bit eoq);
        int gap;
        gap = 0;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (steady_sender) gap = 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoq;
        do @(posedge aclk); while (!s_tready);
        predict_query_byte(c, eoq);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_query_byte(stream_bytes[i], stream_last[i]);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        stream_bytes.delete();
        stream_last.delete();
    endtask

    // Waits until every expected descriptor has come back, and then a little
    // longer so that a last byte with no descriptor has also left the block.
    task automatic wait_for_drain();
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (DRAIN_SETTLE) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Configuration writes. These are only issued after a drain, so the
    // block is idle between queries when they happen.
    // ------------------------------------------------------------------
    task automatic write_register(input logic [1:0] index, input logic [7:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (index)
            REG_WORD_MAX: begin
                word_cap = value;
            end
            REG_NUMBER_MAX: begin
                number_cap = value;
            end
            REG_CHINESE_MAX: begin
                chinese_cap = value;
            end
            default: begin
            end
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_caps(input logic [7:0] word, input logic [7:0] number,
                            input logic [7:0] chinese);
        wait_for_drain();
        write_register(REG_WORD_MAX, word);
        write_register(REG_NUMBER_MAX, number);
        write_register(REG_CHINESE_MAX, chinese);
    endtask

    // ------------------------------------------------------------------
    // Query text generation.
    // ------------------------------------------------------------------
    function automatic logic [7:0] random_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) != 0) ? 8'h41 + c : 8'h61 + c;
    endfunction

    function automatic logic [7:0] random_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] random_lead();
        return 8'($urandom_range(LEAD_LO, LEAD_HI));
    endfunction

    function automatic logic [7:0] random_trail();
        return 8'($urandom_range(TRAIL_LO, TRAIL_HI));
    endfunction

    // A byte that belongs to no token. Some of them are high bytes that hide
    // whatever comes next.
    function automatic logic [7:0] random_separator();
        case ($urandom_range(0, 5))
            0: return 8'h20;
            1: return 8'($urandom_range(8'h21, 8'h2f));
            2: return 8'($urandom_range(8'h01, 8'h1f));
            3: return 8'($urandom_range(8'h5b, 8'h60));
            4: return 8'($urandom_range(8'h80, 8'haf));
            default: return 8'($urandom_range(8'hf8, 8'hff));
        endcase
    endfunction

    function void push_word(input int len);
        push_byte(random_letter());
        repeat (len - 1)
            push_byte(($urandom_range(0, 3) == 0) ? random_digit() : random_letter());
    endfunction

    function void push_number(input int len);
        repeat (len) push_byte(random_digit());
    endfunction

    function void push_chinese_pairs(input int pairs);
        repeat (pairs) begin
            push_byte(random_lead());
            push_byte(random_trail());
        end
    endfunction

    // Mostly well-formed text: tokens of all three kinds, minus signs and
    // separators, with a share of stray bytes and lone lead bytes. The last
    // byte carries the end-of-query flag.
    function void compose_query(input int target, input int long_pct);
        int first;
        int len;
        first = stream_bytes.size();
        while (stream_bytes.size() - first < target) begin
            if ($urandom_range(0, 99) < long_pct) len = $urandom_range(100, 270);
            else len = $urandom_range(1, 9);
            case ($urandom_range(0, 11))
                0, 1, 2: push_word(len);
                3, 4: push_number(len);
                5, 6, 7: push_chinese_pairs((len + 1) / 2);
                8: push_byte(8'($urandom_range(1, 255)));
                9: push_byte(CHAR_MINUS);
                10: push_byte(random_lead());
                default: push_byte(random_separator());
            endcase
            if ($urandom_range(0, 3) != 0) push_byte(random_separator());
        end
        mark_query_end();
    endfunction

    function automatic logic [7:0] random_cap();
        case ($urandom_range(0, 8))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd2;
            3: return 8'd255;
            4: return 8'd254;
            5: return 8'd253;
            default: return 8'($urandom_range(1, 12));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Descriptor receiver. Ready follows a pattern that changes at random
    // intervals, and it includes stretches of constant readiness. A test
    // can ask for one long hold-off, which this process counts down itself.
    // ------------------------------------------------------------------
    rx_pattern_t rx_pattern = RX_ALWAYS;
    int          rx_pattern_left = 0;
    int          rx_phase = 0;
    int          hold_left = 0;
    bit          long_hold_req = 1'b0;

    always @(negedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (rx_pattern_left == 0) begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_pattern_left = $urandom_range(16, 160);
        end else begin
            rx_pattern_left--;
        end
        rx_phase++;
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (rx_pattern)
                RX_ALWAYS: m_tready <= 1'b1;
                RX_COIN: m_tready <= ($urandom_range(0, 1) != 0);
                RX_MOSTLY: m_tready <= ($urandom_range(0, 3) != 0);
                default: m_tready <= (rx_phase % 7) < 4;
            endcase
        end
    end

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Every accepted descriptor is compared with the oldest one still owed.
    always @(posedge aclk) begin
        token_desc_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                $error("descriptor with none expected: tdata %h tuser %h tlast %b",
                       m_tdata, m_tuser, m_tlast);
                error_count++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("token_kind", want.kind, m_tuser);
                check_field("token_start", want.start, m_tdata[9:0]);
                check_field("token_length", want.length, m_tdata[17:10]);
                check_field("negated", want.negated, m_tdata[18]);
                check_field("tdata_pad", 0, m_tdata[OUT_TDATA_W-1:19]);
                check_field("last_of_run", want.last, m_tlast);
            end
        end
    end

    int unsigned cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------
    task automatic apply_reset();
        clear_query_state();
        word_cap    = DEFAULT_WORD_CAP;
        number_cap  = DEFAULT_NUMBER_CAP;
        chinese_cap = DEFAULT_CHINESE_CAP;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
    endtask

    // This runs at the reset caps. It covers a minus before the first token,
    // a word running over digits, a negated number ended by a lead byte,
    // two pairs of extreme lead and trail values, a high byte hiding a letter,
    // a zero byte, a lone lead that uses up a pending minus, and a high byte
    // that ends the query with nothing left to hide.
    task automatic test_directed_defaults();
        logic [7:0] text [19];
        text = '{"-", "a", "1", " ", "-", "7", 8'hb0, 8'ha1, 8'hf7, 8'hfe, "x", 8'h80,
                 "z", 8'h00, "-", 8'hc0, " ", "q", 8'hff};
        foreach (text[i]) push_byte(text[i]);
        mark_query_end();
        send_query_stream_and_drain();
    endtask

    // This uses the smallest caps and then zero caps. Every byte but a trail
    // byte splits the token before it, so one byte can produce two descriptors.
    // A zero cap still allows one byte, or one pair in a Chinese run.
    task automatic test_directed_low_caps();
        logic [7:0] split_text [9];
        logic [7:0] zero_text [9];
        split_text = '{"a", "b", "1", "2", 8'hb0, 8'ha1, 8'hb1, 8'ha2, "9"};
        zero_text  = '{"a", "b", 8'hc0, 8'hc1, 8'hc2, 8'hc3, "1", "-", 8'hd0};
        set_caps(8'd1, 8'd1, 8'd2);
        foreach (split_text[i]) push_byte(split_text[i]);
        mark_query_end();
        send_query_stream_and_drain();
        set_caps(8'd0, 8'd0, 8'd0);
        foreach (zero_text[i]) push_byte(zero_text[i]);
        mark_query_end();
        send_query_stream_and_drain();
    endtask

    task automatic send_query_stream_and_drain();
        send_stream();
        wait_for_drain();
    endtask

    // Tokens at the largest caps: a word and a number one byte over the cap,
    // and a Chinese run two pairs over the 254-byte limit under an odd cap.
    // Filler text then makes the query longer than the position counter, so
    // start positions wrap to zero.
    task automatic test_cap_extremes();
        set_caps(8'd255, 8'd255, 8'd255);
        push_word(256);
        push_byte(" ");
        push_number(256);
        push_byte(" ");
        push_chinese_pairs(129);
        push_byte(".");
        compose_query(260, 0);
        send_stream();
    endtask

    // The receiver holds off for a long stretch while bytes keep coming
    // back to back. The descriptor queue fills and the block stops taking
    // bytes. Afterwards the sender waits for every descriptor before it
    // goes on.
    task automatic test_output_backpressure();
        set_caps(8'd1, 8'd1, 8'd2);
        while (stream_bytes.size() < 150) compose_query($urandom_range(10, 30), 0);
        steady_sender = 1'b1;
        long_hold_req = 1'b1;
        send_stream();
        steady_sender = 1'b0;
        wait_for_drain();
    endtask

    // Phases of random queries, each with its own caps drawn from the
    // extremes and from small values that make the caps bite often.
    task automatic test_random_traffic();
        int first;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            set_caps(random_cap(), random_cap(), random_cap());
            while (stream_bytes.size() < 60) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(1, 20)) push_byte(8'($urandom_range(1, 255)));
                    mark_query_end();
                end else begin
                    compose_query($urandom_range(1, 40), 3);
                end
            end
            send_stream();
        end
    endtask

    initial begin
        apply_reset();
        test_directed_defaults();
        test_directed_low_caps();
        test_cap_extremes();
        test_output_backpressure();
        test_random_traffic();
        wait_for_drain();
        repeat (DRAIN_SETTLE * 2) @(posedge aclk);
        if (error_count == 0 && expected_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
